/* rtl/core/rwag_pkg.sv */
`timescale 1ns / 1ps

package rwag_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int SINE_STEPS     = 1024;
    localparam int DIST_LEVELS    = 512;

    localparam int PIX_W   = 10;
    localparam int LVL_W   = 9;
    localparam int DIM_W   = 11;
    localparam int GAIN_W  = 8;
    localparam int ADDR_W  = 20;
    localparam int IDX_W   = 10;
    localparam int SINE_W  = 16;
    localparam int PHASE_W = 18;
    localparam int MUL_W   = SINE_W + GAIN_W;
    localparam int OFS_W   = MUL_W - 15;
    localparam int CRD_W   = PIX_W + 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd320;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd240;

    localparam logic [63:0] PI52_INT  = 64'h003243F6A8885A30;
    localparam logic [63:0] PI52_FRAC = 64'h000000008D313198;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_X_AMPLITUDE  = 3'd2,
        REG_Y_AMPLITUDE  = 3'd3,
        REG_RIPPLE_STEP  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
    } pix_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } dim_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] x_amp;
        logic signed [GAIN_W-1:0] y_amp;
    } gain_t;

    typedef logic [255:0][14:0] qsine_tab_t;

    // q60 fixed point product
    function automatic logic [63:0] qmul60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // unsigned quotient by shift and subtract, table build only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // truncated q15 sine of the first quarter wave, odd taylor series in q60
    function automatic logic [14:0] quarter_sine(input logic [7:0] q);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] res;
        if (q == 8'd0)
        begin
            return 15'd0;
        end
        x = ((64'(q) * PI52_INT) + ((64'(q) * PI52_FRAC) >> 32)) >> 1;
        x2 = qmul60(x, x);
        term = x;
        sum = x;
        for (int k = 1; k < 20; k++)
        begin
            if (term != 64'd0)
            begin
                term = udiv64(qmul60(term, x2), 64'(2 * k) * 64'(2 * k + 1));
                if ((k & 1) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        res = qmul60(sum, 64'd32767);
        return res[14:0];
    endfunction

    function automatic qsine_tab_t qsine_build();
        qsine_tab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = quarter_sine(8'(i));
        end
        return t;
    endfunction

    localparam qsine_tab_t QSINE = qsine_build();

    // full wave lookup from the quarter table
    function automatic logic signed [SINE_W-1:0] sine_at(input logic [IDX_W-1:0] j);
        logic [IDX_W:0]  q;
        logic            neg;
        logic [14:0]     mag;
        if (j <= 10'd256)
        begin
            q = {1'b0, j};
            neg = 1'b0;
        end
        else if (j <= 10'd512)
        begin
            q = 11'd512 - {1'b0, j};
            neg = 1'b0;
        end
        else if (j <= 10'd768)
        begin
            q = {1'b0, j} - 11'd512;
            neg = 1'b1;
        end
        else
        begin
            q = 11'd1024 - {1'b0, j};
            neg = 1'b1;
        end
        mag = q[8] ? 15'd32767 : QSINE[q[7:0]];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

/* rtl/core/rwag_phase.sv */
`timescale 1ns / 1ps

module rwag_phase (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  rwag_pkg::pix_t                          in_pix,
    input  logic [rwag_pkg::LVL_W-1:0]              in_level,
    input  logic signed [rwag_pkg::GAIN_W-1:0]      ripple,
    output logic                                    out_valid,
    output rwag_pkg::pix_t                          out_pix,
    output logic signed [rwag_pkg::SINE_W-1:0]      out_sin,
    output logic signed [rwag_pkg::SINE_W-1:0]      out_cos
);

    logic                                       v1_reg;
    rwag_pkg::pix_t                             pix1_reg;
    logic signed [rwag_pkg::PHASE_W-1:0]        prod_reg;
    logic signed [rwag_pkg::PHASE_W-1:0]        prod_next;

    logic                                       v2_reg;
    rwag_pkg::pix_t                             pix2_reg;
    logic signed [rwag_pkg::SINE_W-1:0]         sin_reg;
    logic signed [rwag_pkg::SINE_W-1:0]         sin_next;
    logic signed [rwag_pkg::SINE_W-1:0]         cos_reg;
    logic signed [rwag_pkg::SINE_W-1:0]         cos_next;
    logic [rwag_pkg::IDX_W-1:0]                 idx;
    logic [rwag_pkg::IDX_W-1:0]                 cidx;

    assign prod_next = $signed({1'b0, in_level}) * ripple;

    // arithmetic shift by three, then even index only
    assign idx  = {prod_reg[12:4], 1'b0};
    assign cidx = idx + 10'd256;
    assign sin_next = rwag_pkg::sine_at(idx);
    assign cos_next = rwag_pkg::sine_at(cidx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pix1_reg <= in_pix;
        prod_reg <= prod_next;
        pix2_reg <= pix1_reg;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
    end

    assign out_valid = v2_reg;
    assign out_pix   = pix2_reg;
    assign out_sin   = sin_reg;
    assign out_cos   = cos_reg;

endmodule

/* rtl/core/rwag_offset.sv */
`timescale 1ns / 1ps

module rwag_offset (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  rwag_pkg::pix_t                          in_pix,
    input  logic signed [rwag_pkg::SINE_W-1:0]      in_sin,
    input  logic signed [rwag_pkg::SINE_W-1:0]      in_cos,
    input  rwag_pkg::gain_t                         gain,
    output logic                                    out_valid,
    output rwag_pkg::pix_t                          out_pix,
    output logic signed [rwag_pkg::OFS_W-1:0]       out_xoff,
    output logic signed [rwag_pkg::OFS_W-1:0]       out_yoff
);

    logic                                   v3_reg;
    rwag_pkg::pix_t                         pix3_reg;
    logic signed [rwag_pkg::MUL_W-1:0]      xmul_reg;
    logic signed [rwag_pkg::MUL_W-1:0]      xmul_next;
    logic signed [rwag_pkg::MUL_W-1:0]      ymul_reg;
    logic signed [rwag_pkg::MUL_W-1:0]      ymul_next;

    assign xmul_next = in_cos * gain.x_amp;
    assign ymul_next = in_sin * gain.y_amp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pix3_reg <= in_pix;
        xmul_reg <= xmul_next;
        ymul_reg <= ymul_next;
    end

    // floor divide by 2^15
    assign out_valid = v3_reg;
    assign out_pix   = pix3_reg;
    assign out_xoff  = xmul_reg[rwag_pkg::MUL_W-1:15];
    assign out_yoff  = ymul_reg[rwag_pkg::MUL_W-1:15];

endmodule

/* rtl/core/rwag_addr.sv */
`timescale 1ns / 1ps

module rwag_addr (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  rwag_pkg::pix_t                          in_pix,
    input  logic signed [rwag_pkg::OFS_W-1:0]       in_xoff,
    input  logic signed [rwag_pkg::OFS_W-1:0]       in_yoff,
    input  rwag_pkg::dim_t                          dim,
    output logic                                    done,
    output logic [rwag_pkg::PIX_W-1:0]              src_x,
    output logic [rwag_pkg::PIX_W-1:0]              src_y,
    output logic [rwag_pkg::ADDR_W-1:0]             src_addr,
    output logic                                    blank
);

    localparam int CW = rwag_pkg::CRD_W;
    localparam int DW = rwag_pkg::DIM_W;

    logic signed [CW-1:0]   dx;
    logic signed [CW-1:0]   dy;
    logic signed [CW-1:0]   maxx;
    logic signed [CW-1:0]   maxy;
    logic [DW-1:0]          cx_next;
    logic [DW-1:0]          cy_next;
    logic                   blank_next;

    logic                   v4_reg;
    logic [DW-1:0]          cx_reg;
    logic [DW-1:0]          cy_reg;
    logic                   blank4_reg;

    logic                   v5_reg;
    logic [DW-1:0]          cx5_reg;
    logic [DW-1:0]          cy5_reg;
    logic                   blank5_reg;
    logic [2*DW-1:0]        rowp_reg;
    logic [2*DW-1:0]        rowp_next;

    logic                   done_reg;
    logic [rwag_pkg::PIX_W-1:0]  sx_reg;
    logic [rwag_pkg::PIX_W-1:0]  sy_reg;
    logic [rwag_pkg::ADDR_W-1:0] addr_reg;
    logic [rwag_pkg::ADDR_W-1:0] addr_next;
    logic [2*DW-1:0]        addr_sum;
    logic                   blank_reg;

    assign dx   = CW'(in_xoff) + $signed({2'b00, in_pix.px});
    assign dy   = CW'(in_yoff) + $signed({2'b00, in_pix.py});
    assign maxx = $signed({1'b0, dim.width}) - 12'sd2;
    assign maxy = $signed({1'b0, dim.height}) - 12'sd2;
    assign blank_next = ({1'b0, in_pix.py} >= (dim.height - 11'd1));

    always_comb
    begin
        if (dx[CW-1])
            cx_next = '0;
        else if (dx > maxx)
            cx_next = maxx[DW-1:0];
        else
            cx_next = dx[DW-1:0];

        if (dy[CW-1])
            cy_next = '0;
        else if (dy > maxy)
            cy_next = maxy[DW-1:0];
        else
            cy_next = dy[DW-1:0];
    end

    assign rowp_next = cy_reg * dim.width;
    assign addr_sum  = rowp_reg + {{DW{1'b0}}, cx5_reg};
    assign addr_next = addr_sum[rwag_pkg::ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v4_reg   <= in_valid;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        blank4_reg <= blank_next;
        cx5_reg    <= cx_reg;
        cy5_reg    <= cy_reg;
        blank5_reg <= blank4_reg;
        rowp_reg   <= rowp_next;
        // last row and rows past it read as zero
        sx_reg     <= blank5_reg ? '0 : cx5_reg[rwag_pkg::PIX_W-1:0];
        sy_reg     <= blank5_reg ? '0 : cy5_reg[rwag_pkg::PIX_W-1:0];
        addr_reg   <= blank5_reg ? '0 : addr_next;
        blank_reg  <= blank5_reg;
    end

    assign done     = done_reg;
    assign src_x    = sx_reg;
    assign src_y    = sy_reg;
    assign src_addr = addr_reg;
    assign blank    = blank_reg;

endmodule

/* rtl/core/radial_warp_address_gen.sv */
`timescale 1ns / 1ps
// radial sine warp source address generator
// throughput: one item per clock, set by the six stage pipeline with no stalls
// the receiver cannot stall, so busy stays low and start is always taken
// reset: async active low, clears valid bits and loads default frame settings

module radial_warp_address_gen #(
    parameter int MAX_WIDTH  = rwag_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rwag_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // item input
    input  logic                                start,
    output logic                                busy,
    input  logic [rwag_pkg::PIX_W-1:0]          pix_x,
    input  logic [rwag_pkg::PIX_W-1:0]          pix_y,
    input  logic [rwag_pkg::LVL_W-1:0]          dist_level,

    // register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rwag_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rwag_pkg::DIM_W-1:0]          cfg_data,

    // result output, one cycle strobe
    output logic                                done,
    output logic [rwag_pkg::PIX_W-1:0]          src_x,
    output logic [rwag_pkg::PIX_W-1:0]          src_y,
    output logic [rwag_pkg::ADDR_W-1:0]         src_addr,
    output logic                                blank
);

    localparam int DW = rwag_pkg::DIM_W;

    // frame size registers hold the value already saturated to 2..max
    logic [DW-1:0]                          width_reg;
    logic [DW-1:0]                          height_reg;
    logic signed [rwag_pkg::GAIN_W-1:0]     x_amp_reg;
    logic signed [rwag_pkg::GAIN_W-1:0]     y_amp_reg;
    logic signed [rwag_pkg::GAIN_W-1:0]     ripple_reg;
    logic [DW-1:0]                          width_sat;
    logic [DW-1:0]                          height_sat;
    logic                                   cfg_we;
    logic                                   in_accept;

    rwag_pkg::pix_t                         pix_in;
    rwag_pkg::dim_t                         dim;
    rwag_pkg::gain_t                        gain;

    logic                                   ph_valid;
    rwag_pkg::pix_t                         ph_pix;
    logic signed [rwag_pkg::SINE_W-1:0]     ph_sin;
    logic signed [rwag_pkg::SINE_W-1:0]     ph_cos;

    logic                                   of_valid;
    rwag_pkg::pix_t                         of_pix;
    logic signed [rwag_pkg::OFS_W-1:0]      of_xoff;
    logic signed [rwag_pkg::OFS_W-1:0]      of_yoff;

    // no backpressure anywhere: an item enters every cycle that start is high
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_accept = start & ~busy;
    assign cfg_we    = cfg_valid & cfg_ready;

    // saturate frame dimensions at write time
    always_comb
    begin
        if (cfg_data < 11'd2)
            width_sat = 11'd2;
        else if (32'(cfg_data) > MAX_WIDTH)
            width_sat = DW'(MAX_WIDTH);
        else
            width_sat = cfg_data;

        if (cfg_data < 11'd2)
            height_sat = 11'd2;
        else if (32'(cfg_data) > MAX_HEIGHT)
            height_sat = DW'(MAX_HEIGHT);
        else
            height_sat = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rwag_pkg::WIDTH_RST;
            height_reg <= rwag_pkg::HEIGHT_RST;
            x_amp_reg  <= '0;
            y_amp_reg  <= '0;
            ripple_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rwag_pkg::REG_FRAME_WIDTH:  width_reg  <= width_sat;
                rwag_pkg::REG_FRAME_HEIGHT: height_reg <= height_sat;
                rwag_pkg::REG_X_AMPLITUDE:  x_amp_reg  <= cfg_data[rwag_pkg::GAIN_W-1:0];
                rwag_pkg::REG_Y_AMPLITUDE:  y_amp_reg  <= cfg_data[rwag_pkg::GAIN_W-1:0];
                rwag_pkg::REG_RIPPLE_STEP:  ripple_reg <= cfg_data[rwag_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pix_in.px   = pix_x;
    assign pix_in.py   = pix_y;
    assign dim.width   = width_reg;
    assign dim.height  = height_reg;
    assign gain.x_amp  = x_amp_reg;
    assign gain.y_amp  = y_amp_reg;

    // stages 1-2: phase product, then quarter wave sine and cosine lookup
    rwag_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_accept),
        .in_pix    (pix_in),
        .in_level  (dist_level),
        .ripple    (ripple_reg),
        .out_valid (ph_valid),
        .out_pix   (ph_pix),
        .out_sin   (ph_sin),
        .out_cos   (ph_cos)
    );

    // stage 3: gain multiply, floor shift by 15 on the way out
    rwag_offset u_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ph_valid),
        .in_pix    (ph_pix),
        .in_sin    (ph_sin),
        .in_cos    (ph_cos),
        .gain      (gain),
        .out_valid (of_valid),
        .out_pix   (of_pix),
        .out_xoff  (of_xoff),
        .out_yoff  (of_yoff)
    );

    // stages 4-6: clamp and blank test, row times width, add column
    rwag_addr u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (of_valid),
        .in_pix    (of_pix),
        .in_xoff   (of_xoff),
        .in_yoff   (of_yoff),
        .dim       (dim),
        .done      (done),
        .src_x     (src_x),
        .src_y     (src_y),
        .src_addr  (src_addr),
        .blank     (blank)
    );

endmodule
